// File: sv/lsfbr_pkg.sv
// Shared types, register indexes and status codes of the line-scan feature and barcode reader.
`timescale 1ns / 1ps

package lsfbr_pkg;

    localparam int IMAGE_MAX_DEF = 128;
    localparam int MAX_RUNS_DEF  = 32;
    localparam int CODE_BITS_DEF = 8;
    localparam int QUEUE_DEPTH   = 2;

    // Fixed widths of the line record, sized for the largest parameter values.
    localparam int REC_LEN_W   = 7;
    localparam int REC_SUM_W   = 9;
    localparam int REC_WIDTH_W = 8;
    localparam int REC_LANES   = 8;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_THRESHOLD     = 3'd0;
    localparam logic [2:0] REG_COARSENESS    = 3'd1;
    localparam logic [2:0] REG_KEEP_ABOVE    = 3'd2;
    localparam logic [2:0] REG_KEEP_BELOW    = 3'd3;
    localparam logic [2:0] REG_FEATURE_LIMIT = 3'd4;
    localparam logic [2:0] REG_SKIP_COUNT    = 3'd5;
    localparam logic [2:0] REG_NEEDED_BITS   = 3'd6;

    localparam logic [1:0] CODE_OK      = 2'd0;
    localparam logic [1:0] CODE_NO_RUNS = 2'd1;
    localparam logic [1:0] CODE_TOO_FEW = 2'd2;

    typedef struct packed {
        logic [7:0] pixel;
        logic       line_end;
    } t_pixel_item;

    typedef struct packed {
        logic [5:0] run_count;
        logic       line_status;
        logic [7:0] line_centre;
        logic [1:0] code_status;
        logic [7:0] code_byte;
    } t_result;

    typedef struct packed {
        logic [7:0] threshold;
        logic [7:0] coarseness;
        logic [7:0] keep_above;
        logic [7:0] keep_below;
        logic [5:0] feature_limit;
        logic [5:0] skip_count;
        logic [7:0] needed_bits;
    } t_cfg;

    typedef struct packed {
        logic [5:0]                                 run_count;
        logic                                       line_status;
        logic [7:0]                                 line_centre;
        logic [1:0]                                 code_status;
        logic [REC_LEN_W-1:0]                       len;
        logic [REC_SUM_W-1:0]                       sum;
        logic [REC_LANES-1:0][REC_WIDTH_W-1:0]      widths;
    } t_line_rec;

endpackage

// File: sv/line_scan_feature_barcode_reader.sv
// Top level of the line-scan feature and barcode reader: register port, front, queue, back.
`timescale 1ns / 1ps
//
// Usage:
//   Pixel channel: drive i_pixel_item and raise push; an item is taken at a clock
//   edge with push high and full low. Set line_end on the last pixel of a line.
//   Result channel: one result per line. While empty is low the oldest result
//   sits on o_result; raise pop to take it.
//   Register port: APB-style, pready tied high, register i at byte address 4*i.
//   Write registers only while no line is in progress and no result is pending.
// Timing:
//   One pixel per cycle while full is low; the per-pixel update in the front part
//   is a pair of threshold compares and small counters, computed combinationally.
//   A line's record enters the record queue as its line_end pixel is taken, then
//   moves into the output register (the code-bit multipliers) once that is free.
// Reset:
//   Registers return to their defaults, line state clears, queue and output
//   empty. No clearing pass: the block takes pixels right after reset.
// Stall:
//   A stalled receiver holds the output register; up to two more line records
//   wait in the queue, after which full rises and pixels hold off.

module line_scan_feature_barcode_reader #(
    parameter int IMAGE_MAX = lsfbr_pkg::IMAGE_MAX_DEF,
    parameter int MAX_RUNS  = lsfbr_pkg::MAX_RUNS_DEF,
    parameter int CODE_BITS = lsfbr_pkg::CODE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // pixel channel
    input  logic                             push,
    output logic                             full,
    input  lsfbr_pkg::t_pixel_item           i_pixel_item,
    // result channel
    output logic                             empty,
    input  logic                             pop,
    output lsfbr_pkg::t_result               o_result,
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lsfbr_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    lsfbr_pkg::t_cfg      r_cfg;
    lsfbr_pkg::t_line_rec front_rec, queue_rec;
    logic                 take, rec_push, q_full, q_empty, rec_pop;
    logic                 cfg_write;
    logic [2:0]           reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register file: hold values between writes, ignore addresses past the list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold     <= 8'd128;
            r_cfg.coarseness    <= 8'd0;
            r_cfg.keep_above    <= 8'd0;
            r_cfg.keep_below    <= 8'd255;
            r_cfg.feature_limit <= 6'd32;
            r_cfg.skip_count    <= 6'd0;
            r_cfg.needed_bits   <= 8'd8;
        end else if (cfg_write) begin
            case (reg_index)
                lsfbr_pkg::REG_THRESHOLD:     r_cfg.threshold     <= pwdata[7:0];
                lsfbr_pkg::REG_COARSENESS:    r_cfg.coarseness    <= pwdata[7:0];
                lsfbr_pkg::REG_KEEP_ABOVE:    r_cfg.keep_above    <= pwdata[7:0];
                lsfbr_pkg::REG_KEEP_BELOW:    r_cfg.keep_below    <= pwdata[7:0];
                lsfbr_pkg::REG_FEATURE_LIMIT: r_cfg.feature_limit <= pwdata[5:0];
                lsfbr_pkg::REG_SKIP_COUNT:    r_cfg.skip_count    <= pwdata[5:0];
                lsfbr_pkg::REG_NEEDED_BITS:   r_cfg.needed_bits   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Read back: zero-extend each register to the bus.
    always_comb begin
        case (reg_index)
            lsfbr_pkg::REG_THRESHOLD:     prdata = 32'(r_cfg.threshold);
            lsfbr_pkg::REG_COARSENESS:    prdata = 32'(r_cfg.coarseness);
            lsfbr_pkg::REG_KEEP_ABOVE:    prdata = 32'(r_cfg.keep_above);
            lsfbr_pkg::REG_KEEP_BELOW:    prdata = 32'(r_cfg.keep_below);
            lsfbr_pkg::REG_FEATURE_LIMIT: prdata = 32'(r_cfg.feature_limit);
            lsfbr_pkg::REG_SKIP_COUNT:    prdata = 32'(r_cfg.skip_count);
            lsfbr_pkg::REG_NEEDED_BITS:   prdata = 32'(r_cfg.needed_bits);
            default:                      prdata = 32'd0;
        endcase
    end

    // Hold pixels off only when no room is left for another line record.
    assign full = q_full;
    assign take = push && !full;

    lsfbr_front #(
        .IMAGE_MAX (IMAGE_MAX),
        .MAX_RUNS  (MAX_RUNS),
        .CODE_BITS (CODE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_take     (take),
        .i_item     (i_pixel_item),
        .o_rec_push (rec_push),
        .o_rec      (front_rec)
    );

    lsfbr_queue #(
        .DEPTH (lsfbr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_data  (front_rec),
        .o_full  (q_full),
        .i_pop   (rec_pop),
        .o_data  (queue_rec),
        .o_empty (q_empty)
    );

    lsfbr_back #(
        .CODE_BITS (CODE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (queue_rec),
        .i_rec_valid (!q_empty),
        .o_rec_pop   (rec_pop),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    // A line end always lands a record in the queue.
    a_line_end_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_pixel_item.line_end) |=> !q_empty)
        else $error("line end accepted but queue stayed empty");

    // An idle output register picks up a waiting record at the next edge.
    a_back_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !q_empty) |=> !empty)
        else $error("waiting record not moved to the output");

    // Code bits only accompany a valid code.
    a_byte_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.code_byte != 8'd0) |-> (o_result.code_status == lsfbr_pkg::CODE_OK))
        else $error("code byte set without a valid code");

    // No runs means centre invalid and no code.
    a_no_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.run_count == 6'd0) |->
        (o_result.line_status && o_result.code_status == lsfbr_pkg::CODE_NO_RUNS))
        else $error("empty line reported with runs");

endmodule

// File: sv/lsfbr_front.sv
// Front part: per-pixel run segmentation and line record assembly.
`timescale 1ns / 1ps

module lsfbr_front #(
    parameter int IMAGE_MAX = lsfbr_pkg::IMAGE_MAX_DEF,
    parameter int MAX_RUNS  = lsfbr_pkg::MAX_RUNS_DEF,
    parameter int CODE_BITS = lsfbr_pkg::CODE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lsfbr_pkg::t_cfg        i_cfg,
    input  logic                   i_take,
    input  lsfbr_pkg::t_pixel_item i_item,
    output logic                   o_rec_push,
    output lsfbr_pkg::t_line_rec   o_rec
);

    localparam int POS_W = $clog2(IMAGE_MAX + 1);
    localparam int N_W   = $clog2(IMAGE_MAX);
    localparam int K_W   = $clog2(MAX_RUNS + 1);
    localparam int LIM_W = (K_W > 6) ? K_W : 6;
    localparam int IDX_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
    localparam int SUM_W = POS_W;

    logic [POS_W-1:0] r_pos,    n_pos;
    logic             r_light,  n_light;
    logic [N_W-1:0]   r_start,  n_start;
    logic [K_W-1:0]   r_kept,   n_kept;
    logic [7:0]       r_centre, n_centre;
    logic [SUM_W-1:0] r_sum,    n_sum;
    logic [N_W-1:0]   r_widths [CODE_BITS];
    logic [N_W-1:0]   n_widths [CODE_BITS];

    logic [LIM_W-1:0] limit, kept_x, skip_x, idx, nk_x, len_x;
    logic [8:0]       hi;
    logic signed [9:0] lo;
    logic             px_lo, active, keep;
    logic [N_W-1:0]   n_here, w;
    logic [7:0]       w8;
    logic [N_W:0]     centre_sum;

    always_comb begin
        limit = (LIM_W'(i_cfg.feature_limit) > LIM_W'(MAX_RUNS)) ?
                LIM_W'(MAX_RUNS) : LIM_W'(i_cfg.feature_limit);
        kept_x = LIM_W'(r_kept);
        skip_x = LIM_W'(i_cfg.skip_count);
        idx    = kept_x - skip_x;
        hi     = {1'b0, i_cfg.threshold} + {1'b0, i_cfg.coarseness};
        lo     = $signed({2'b00, i_cfg.threshold}) - $signed({2'b00, i_cfg.coarseness});
        px_lo  = $signed({2'b00, i_item.pixel}) < lo;
        active = r_pos < POS_W'(IMAGE_MAX);
        n_here = r_pos[N_W-1:0];
        w      = n_here - r_start;
        w8     = 8'(w);
        keep   = (w8 > i_cfg.keep_above) && (w8 < i_cfg.keep_below);
        centre_sum = (N_W+1)'(r_start) + (N_W+1)'(w >> 1);
    end

    always_comb begin
        n_pos    = r_pos;
        n_light  = r_light;
        n_start  = r_start;
        n_kept   = r_kept;
        n_centre = r_centre;
        n_sum    = r_sum;
        n_widths = r_widths;
        if (i_take && active) begin
            n_pos = r_pos + 1'b1;
            // Once the run limit is reached, freeze segmentation for the line.
            if (kept_x < limit) begin
                if (!r_light) begin
                    if ({1'b0, i_item.pixel} > hi) begin
                        n_light = 1'b1;
                        n_start = n_here;
                    end
                end else if (px_lo) begin
                    n_light = 1'b0;
                    if (keep) begin
                        if (r_kept == '0) begin
                            n_centre = 8'(centre_sum);
                        end
                        if (kept_x >= skip_x) begin
                            n_sum = r_sum + SUM_W'(w);
                            if (idx < LIM_W'(CODE_BITS)) begin
                                n_widths[idx[IDX_W-1:0]] = w;
                            end
                        end
                        n_kept = r_kept + 1'b1;
                    end
                end
            end
        end
    end

    // Line record built from the state after the last pixel.
    always_comb begin
        nk_x  = LIM_W'(n_kept);
        len_x = '0;
        o_rec = '0;
        o_rec.run_count   = 6'(n_kept);
        o_rec.line_status = (n_kept == '0);
        o_rec.line_centre = (n_kept == '0) ? 8'd0 : n_centre;
        if (nk_x <= skip_x) begin
            o_rec.code_status = lsfbr_pkg::CODE_NO_RUNS;
        end else begin
            len_x = nk_x - skip_x;
            if (8'(len_x) < i_cfg.needed_bits) begin
                o_rec.code_status = lsfbr_pkg::CODE_TOO_FEW;
            end else begin
                o_rec.code_status = lsfbr_pkg::CODE_OK;
            end
        end
        o_rec.len = lsfbr_pkg::REC_LEN_W'(len_x);
        o_rec.sum = lsfbr_pkg::REC_SUM_W'(n_sum);
        for (int i = 0; i < CODE_BITS; i++) begin
            o_rec.widths[i] = lsfbr_pkg::REC_WIDTH_W'(n_widths[i]);
        end
    end

    assign o_rec_push = i_take && i_item.line_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_light  <= 1'b0;
            r_start  <= '0;
            r_kept   <= '0;
            r_centre <= '0;
            r_sum    <= '0;
        end else if (i_take && i_item.line_end) begin
            r_pos    <= '0;
            r_light  <= 1'b0;
            r_start  <= '0;
            r_kept   <= '0;
            r_centre <= '0;
            r_sum    <= '0;
        end else begin
            r_pos    <= n_pos;
            r_light  <= n_light;
            r_start  <= n_start;
            r_kept   <= n_kept;
            r_centre <= n_centre;
            r_sum    <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_widths <= n_widths;
    end

endmodule

// File: sv/lsfbr_queue.sv
// Short queue of line records between the front and back parts.
`timescale 1ns / 1ps

module lsfbr_queue #(
    parameter int DEPTH = lsfbr_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lsfbr_pkg::t_line_rec i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output lsfbr_pkg::t_line_rec o_data,
    output logic                 o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lsfbr_pkg::t_line_rec r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: sv/lsfbr_back.sv
// Back part: above-average width test per code bit and the result register.
`timescale 1ns / 1ps

module lsfbr_back #(
    parameter int CODE_BITS = lsfbr_pkg::CODE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lsfbr_pkg::t_line_rec i_rec,
    input  logic                 i_rec_valid,
    output logic                 o_rec_pop,
    output lsfbr_pkg::t_result   o_result,
    output logic                 o_empty,
    input  logic                 i_pop
);

    localparam int PROD_W = lsfbr_pkg::REC_WIDTH_W + lsfbr_pkg::REC_LEN_W;

    logic               r_valid;
    lsfbr_pkg::t_result r_result;
    lsfbr_pkg::t_result n_result;
    logic [PROD_W-1:0]  lane_prod [lsfbr_pkg::REC_LANES];
    logic               load;

    // One narrow multiplier per code bit: width * count > sum.
    always_comb begin
        n_result             = '0;
        n_result.run_count   = i_rec.run_count;
        n_result.line_status = i_rec.line_status;
        n_result.line_centre = i_rec.line_centre;
        n_result.code_status = i_rec.code_status;
        for (int i = 0; i < lsfbr_pkg::REC_LANES; i++) begin
            lane_prod[i] = PROD_W'(i_rec.widths[i]) * PROD_W'(i_rec.len);
        end
        for (int i = 0; i < CODE_BITS; i++) begin
            n_result.code_byte[i] = (i_rec.code_status == lsfbr_pkg::CODE_OK) &&
                                    (lsfbr_pkg::REC_LEN_W'(i) < i_rec.len) &&
                                    (lane_prod[i] > PROD_W'(i_rec.sum));
        end
    end

    assign load      = i_rec_valid && (!r_valid || i_pop);
    assign o_rec_pop = load;
    assign o_empty   = !r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= n_result;
        end
    end

endmodule

// File: tb/sv/line_scan_feature_barcode_reader_test.sv
// Self-checking testbench of the line-scan feature and barcode reader.
`timescale 1ns / 1ps

// Drive pixel lines into the reader and check every line result against a predictor
// kept in step with the register settings.
//
// Sender: a clocked driver drains a queue of pending pixel items that the initial
// block fills one phase at a time. Each accepted item advances the predictor, which
// queues the expected result when the item closes a line.
// Receiver: a clocked monitor pops results with random stalls and compares each one,
// field by field, with the oldest expected result.
// Registers are rewritten only between phases, once every expected result has arrived.
// Phases cover the register extremes, the run limit (a limit above the largest run
// count included), skips at or above the run count, long lines and a long receiver
// hold-off that fills the block and stalls its pixel input.

module line_scan_feature_barcode_reader_test;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 8;
    localparam int RANDOM_ITEMS = 700;
    localparam int PRESSURE     = 1;

    // line_status codes
    localparam logic LINE_FOUND = 1'b0;
    localparam logic LINE_EMPTY = 1'b1;

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         push         = 1'b0;
    logic                         full;
    lsfbr_pkg::t_pixel_item       i_pixel_item = '0;
    logic                         empty;
    logic                         pop          = 1'b0;
    lsfbr_pkg::t_result           o_result;
    logic                         psel         = 1'b0;
    logic                         penable      = 1'b0;
    logic                         pwrite       = 1'b0;
    logic [lsfbr_pkg::ADDR_W-1:0] paddr        = '0;
    logic [31:0]                  pwdata       = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    line_scan_feature_barcode_reader DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_pixel_item (i_pixel_item),
        .empty        (empty),
        .pop          (pop),
        .o_result     (o_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Register settings as last written, and the work queues.
    lsfbr_pkg::t_cfg        cfg_now;
    lsfbr_pkg::t_pixel_item pixels_pending[$];
    lsfbr_pkg::t_result     lines_due[$];

    int errors       = 0;
    int cycles       = 0;
    int random_items = 0;
    int hold_token   = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int send_gap     = 0;
    int send_burst   = 0;
    int recv_gap     = 0;
    int recv_burst   = 0;

    // Line tracking state of the predictor.
    logic [7:0] pos_now     = '0;
    logic       in_light    = 1'b0;
    logic [6:0] light_start = '0;
    logic [5:0] kept_now    = '0;
    logic [7:0] centre_now  = '0;
    logic [6:0] lane_width [lsfbr_pkg::CODE_BITS_DEF];
    logic [7:0] lane_sum    = '0;

    // Advance the line state by one accepted pixel; on the last pixel queue the line result.
    task automatic follow_pixel(input lsfbr_pkg::t_pixel_item it);
        int                 limit;
        int                 upper;
        int                 lower;
        int                 w;
        int                 idx;
        int                 len;
        lsfbr_pkg::t_result r;
        limit = (int'(cfg_now.feature_limit) > lsfbr_pkg::MAX_RUNS_DEF) ?
                lsfbr_pkg::MAX_RUNS_DEF : int'(cfg_now.feature_limit);
        upper = int'(cfg_now.threshold) + int'(cfg_now.coarseness);
        lower = int'(cfg_now.threshold) - int'(cfg_now.coarseness);
        // Pixels past the end of the image are ignored; once the run limit is hit,
        // no run opens or closes for the rest of the line.
        if (int'(pos_now) < lsfbr_pkg::IMAGE_MAX_DEF) begin
            if (int'(kept_now) < limit) begin
                if (!in_light) begin
                    if (int'(it.pixel) > upper) begin
                        in_light    = 1'b1;
                        light_start = pos_now[6:0];
                    end
                end else if (int'(it.pixel) < lower) begin
                    w        = int'(pos_now) - int'(light_start);
                    in_light = 1'b0;
                    if (w > int'(cfg_now.keep_above) && w < int'(cfg_now.keep_below)) begin
                        if (kept_now == 0)
                            centre_now = 8'(int'(light_start) + w / 2);
                        if (kept_now >= cfg_now.skip_count) begin
                            idx      = int'(kept_now) - int'(cfg_now.skip_count);
                            lane_sum = lane_sum + 8'(w);
                            if (idx < lsfbr_pkg::CODE_BITS_DEF)
                                lane_width[idx] = 7'(w);
                        end
                        kept_now = kept_now + 6'd1;
                    end
                end
            end
            pos_now = pos_now + 8'd1;
        end

        if (it.line_end) begin
            r.run_count   = kept_now;
            r.line_status = (kept_now == 0) ? LINE_EMPTY : LINE_FOUND;
            r.line_centre = (kept_now == 0) ? 8'd0 : centre_now;
            r.code_byte   = '0;
            if (kept_now <= cfg_now.skip_count) begin
                r.code_status = lsfbr_pkg::CODE_NO_RUNS;
            end else begin
                len = int'(kept_now) - int'(cfg_now.skip_count);
                if (len < int'(cfg_now.needed_bits)) begin
                    r.code_status = lsfbr_pkg::CODE_TOO_FEW;
                end else begin
                    r.code_status = lsfbr_pkg::CODE_OK;
                    // Exact above-average test: width * count > sum.
                    for (int i = 0; i < lsfbr_pkg::CODE_BITS_DEF && i < len; i++)
                        if (int'(lane_width[i]) * len > int'(lane_sum))
                            r.code_byte[i] = 1'b1;
                end
            end
            lines_due.push_back(r);
            // Clear all line state after the result.
            pos_now     = '0;
            in_light    = 1'b0;
            light_start = '0;
            kept_now    = '0;
            centre_now  = '0;
            lane_sum    = '0;
            foreach (lane_width[i])
                lane_width[i] = '0;
        end
    endtask

    task automatic report(input string field, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    task automatic check_line(input lsfbr_pkg::t_result got);
        lsfbr_pkg::t_result want;
        if (lines_due.size() == 0) begin
            errors++;
            $display("%0t: result %h with no line pending", $time, got);
        end else begin
            want = lines_due.pop_front();
            if (got.run_count !== want.run_count)
                report("run_count", want.run_count, got.run_count);
            if (got.line_status !== want.line_status)
                report("line_status", want.line_status, got.line_status);
            if (got.line_centre !== want.line_centre)
                report("line_centre", want.line_centre, got.line_centre);
            if (got.code_status !== want.code_status)
                report("code_status", want.code_status, got.code_status);
            if (got.code_byte !== want.code_byte)
                report("code_byte", want.code_byte, got.code_byte);
        end
    endtask

    // Sender: offer the oldest pending item, advance the predictor on each acceptance,
    // then idle for a random number of cycles (none during a burst).
    always @(posedge i_clk) begin : sender
        logic nxt_push;
        nxt_push = push;
        if (push && !full) begin
            follow_pixel(i_pixel_item);
            void'(pixels_pending.pop_front());
            nxt_push = 1'b0;
            if (send_burst > 0)
                send_burst--;
            else if ($urandom_range(0, 19) == 0)
                send_burst = $urandom_range(10, 40);
            send_gap = (send_burst > 0) ? 0 : $urandom_range(0, 11);
        end
        if (!nxt_push) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pixels_pending.size() > 0 && i_rst_n) begin
                nxt_push = 1'b1;
                i_pixel_item <= pixels_pending[0];
            end
        end
        push <= nxt_push;
    end

    // Receiver: check each popped result, stall at random, and hold off for a long
    // stretch whenever a new hold-off is requested.
    always @(posedge i_clk) begin : receiver
        logic nxt_pop;
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
        end
        if (i_rst_n && pop && !empty) begin
            check_line(o_result);
            if (recv_burst > 0)
                recv_burst--;
            else if ($urandom_range(0, 19) == 0)
                recv_burst = $urandom_range(10, 40);
            recv_gap = (recv_burst > 0) ? 0 : $urandom_range(0, 11);
        end
        if (hold_left > 0) begin
            hold_left--;
            nxt_pop = 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            nxt_pop = 1'b0;
        end else begin
            nxt_pop = 1'b1;
        end
        pop <= nxt_pop;
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, lines_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Wait until every item is accepted and every result checked, then let the pipe drain.
    task automatic wait_idle();
        while (pixels_pending.size() != 0 || push || lines_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lsfbr_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Rewrite every register while the block is idle.
    task automatic apply_config(input lsfbr_pkg::t_cfg c);
        wait_idle();
        write_reg(lsfbr_pkg::REG_THRESHOLD,     c.threshold);
        write_reg(lsfbr_pkg::REG_COARSENESS,    c.coarseness);
        write_reg(lsfbr_pkg::REG_KEEP_ABOVE,    c.keep_above);
        write_reg(lsfbr_pkg::REG_KEEP_BELOW,    c.keep_below);
        write_reg(lsfbr_pkg::REG_FEATURE_LIMIT, 8'(c.feature_limit));
        write_reg(lsfbr_pkg::REG_SKIP_COUNT,    8'(c.skip_count));
        write_reg(lsfbr_pkg::REG_NEEDED_BITS,   c.needed_bits);
        cfg_now = c;
        @(negedge i_clk);
    endtask

    task automatic queue_pixel(input logic [7:0] px, input logic last);
        lsfbr_pkg::t_pixel_item it;
        it.pixel    = px;
        it.line_end = last;
        pixels_pending.push_back(it);
    endtask

    // Queue one line of alternating dark and light runs, with some noise pixels.
    // Dense lines use very short runs so that the run limit is reached.
    task automatic queue_line(input int n_pix, input bit dense);
        int                     run_left;
        int                     lo_band;
        int                     hi_band;
        logic                   light;
        lsfbr_pkg::t_pixel_item it;
        lo_band  = int'(cfg_now.threshold) - int'(cfg_now.coarseness);
        hi_band  = int'(cfg_now.threshold) + int'(cfg_now.coarseness);
        light    = 1'($urandom_range(0, 1));
        run_left = 0;
        for (int k = 0; k < n_pix; k++) begin
            if (run_left == 0) begin
                light    = !light;
                run_left = dense ? $urandom_range(1, 2)
                                 : (light ? $urandom_range(1, 9) : $urandom_range(1, 5));
            end
            run_left--;
            if ($urandom_range(0, 9) == 0)
                it.pixel = 8'($urandom);
            else if (light)
                it.pixel = (hi_band < 255) ? 8'($urandom_range(hi_band + 1, 255)) : 8'd255;
            else
                it.pixel = (lo_band > 0) ? 8'($urandom_range(0, lo_band - 1)) : 8'd0;
            it.line_end = (k == n_pix - 1);
            pixels_pending.push_back(it);
        end
    endtask

    // Random settings for a phase; phase 3 pins every register to an extreme, other phases pin selected registers.
    function automatic lsfbr_pkg::t_cfg pick_config(input int phase);
        lsfbr_pkg::t_cfg c;
        c.threshold     = 8'($urandom_range(60, 200));
        c.coarseness    = 8'($urandom_range(0, 30));
        c.keep_above    = 8'($urandom_range(0, 2));
        c.keep_below    = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(3, 10)) : 8'd255;
        c.feature_limit = 6'($urandom_range(1, 33));
        c.skip_count    = 6'($urandom_range(0, 4));
        c.needed_bits   = 8'($urandom_range(0, 6));
        case (phase)
            2: begin
                // limit above the largest run count, skip swallowing every run
                c.threshold     = 8'd128;
                c.coarseness    = 8'd0;
                c.keep_above    = 8'd0;
                c.keep_below    = 8'd255;
                c.feature_limit = 6'd63;
                c.skip_count    = 6'd32;
                c.needed_bits   = 8'd0;
            end
            3: begin
                c.threshold     = 8'd0;
                c.coarseness    = 8'd255;
                c.keep_above    = 8'd255;
                c.keep_below    = 8'd0;
                c.feature_limit = 6'd0;
                c.skip_count    = 6'd63;
                c.needed_bits   = 8'd255;
            end
            4: begin
                // nothing can be light
                c.threshold     = 8'd255;
                c.coarseness    = 8'd0;
                c.feature_limit = 6'd32;
                c.skip_count    = 6'd0;
                c.needed_bits   = 8'd255;
            end
            5: begin
                // many runs, more than the code bits
                c.keep_above    = 8'd0;
                c.keep_below    = 8'd255;
                c.feature_limit = 6'd40;
                c.skip_count    = 6'($urandom_range(0, 3));
                c.needed_bits   = 8'd0;
            end
            6: begin
                c.feature_limit = 6'd2;
                c.skip_count    = 6'd0;
                c.needed_bits   = 8'd1;
            end
            default: ;
        endcase
        return c;
    endfunction

    initial begin
        lsfbr_pkg::t_cfg c;
        int              phase;
        int              n_phase;
        int              target;
        int              len;
        bit              dense;

        cfg_now.threshold     = 8'd128;
        cfg_now.coarseness    = 8'd0;
        cfg_now.keep_above    = 8'd0;
        cfg_now.keep_below    = 8'd255;
        cfg_now.feature_limit = 6'd32;
        cfg_now.skip_count    = 6'd0;
        cfg_now.needed_bits   = 8'd8;
        foreach (lane_width[i])
            lane_width[i] = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, reset settings first.
        // Single-pixel line, all dark: no runs, nothing after the skip.
        queue_pixel(8'd0, 1'b1);
        // Pixel at the threshold holds light; the trailing open run is dropped; too few runs.
        queue_pixel(8'd255, 1'b0); queue_pixel(8'd255, 1'b0); queue_pixel(8'd128, 1'b0);
        queue_pixel(8'd0, 1'b0);   queue_pixel(8'd255, 1'b0); queue_pixel(8'd255, 1'b1);

        // Four runs of widths 1, 2, 1, 3: a valid code of two bits set.
        c = cfg_now;
        c.needed_bits = 8'd2;
        apply_config(c);
        queue_pixel(8'd200, 1'b0); queue_pixel(8'd10, 1'b0);
        queue_pixel(8'd200, 1'b0); queue_pixel(8'd201, 1'b0); queue_pixel(8'd10, 1'b0);
        queue_pixel(8'd200, 1'b0); queue_pixel(8'd10, 1'b0);
        queue_pixel(8'd200, 1'b0); queue_pixel(8'd200, 1'b0); queue_pixel(8'd200, 1'b0);
        queue_pixel(8'd10, 1'b1);

        // Hysteresis band edges: 120 and 80 leave the state as it is.
        c.threshold  = 8'd100;
        c.coarseness = 8'd20;
        apply_config(c);
        queue_pixel(8'd121, 1'b0); queue_pixel(8'd100, 1'b0); queue_pixel(8'd79, 1'b0);
        queue_pixel(8'd100, 1'b0); queue_pixel(8'd120, 1'b0); queue_pixel(8'd121, 1'b0);
        queue_pixel(8'd80, 1'b1);

        // Random phases: well-formed lines with noise, mostly short, some past the image end.
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            apply_config(pick_config(phase));
            target = (phase == PRESSURE || phase == 2 || phase == 5) ? 100 : 60;
            // Hold the receiver off while the sender keeps offering short lines.
            if (phase == PRESSURE)
                hold_token++;
            n_phase = 0;
            while (n_phase < target && random_items + n_phase < RANDOM_ITEMS) begin
                dense = (phase == 2 || phase == 5) || ($urandom_range(0, 3) == 0);
                if (phase == PRESSURE)
                    len = $urandom_range(2, 6);
                else if (phase == 2 || phase == 5 || $urandom_range(0, 11) == 0)
                    len = $urandom_range(129, 170);
                else
                    len = $urandom_range(1, 60);
                queue_line(len, dense);
                n_phase += len;
            end
            random_items += n_phase;
            phase++;
        end

        wait_idle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
